/* sv/olkr_pkg.sv */
// Shared types and constants for the ordered list with key removal.
`default_nettype none

package olkr_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_APPEND,
        REQ_POP,
        REQ_REMOVE,
        REQ_CONTAINS
    } t_req;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SCAN,
        S_DONE
    } t_state;

    localparam logic [DATA_W-1:0] POP_EMPTY = '1;

endpackage

`default_nettype wire

/* sv/ordered_list_with_key_removal_top.sv */
// Ordered list with key removal: circular buffer in RAM with scan sequencer.
// Append, pop from empty and append to full go straight to the done state, then to the result register.
// Pop passes through a wait state for its RAM read of the head entry. Remove-key and contains scan,
// one entry read per cycle through the single RAM read port; remove-key compacts the list in place.
// One word in flight: the next word is accepted in the cycle after the result registers.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
`default_nettype none

module ordered_list_with_key_removal_top #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic      [1:0]         o_status,
    output logic signed [31:0]      o_popped,
    output logic                    o_found,
    output logic      [4:0]         o_count
);

    import olkr_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_occ, n_occ;
    t_req                r_req, n_req;
    logic [DATA_W-1:0]   r_key, n_key;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_kept, n_kept;
    logic [AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]       r_wr_ptr, n_wr_ptr;
    logic                r_dvalid, n_dvalid;
    t_status             r_status, n_status;
    logic [DATA_W-1:0]   r_popped, n_popped;
    logic                r_found, n_found;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_status, n_out_status;
    logic [DATA_W-1:0]   r_out_popped, n_out_popped;
    logic                r_out_found, n_out_found;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    logic                in_accept;
    logic                slot_free;
    logic                scan_end;
    logic [AW:0]         tail_sum;
    logic [AW-1:0]       tail;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    olkr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign scan_end   = (r_idx == r_occ) && !r_dvalid;
    assign tail_sum   = {1'b0, r_head} + (AW + 1)'(r_occ);
    assign tail       = (tail_sum >= (AW + 1)'(DEPTH)) ?
                        AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (t_req'(i_req_type))
                        REQ_APPEND:   n_state = S_DONE;
                        REQ_POP:      n_state = (r_occ == '0) ? S_DONE : S_POP_WAIT;
                        REQ_REMOVE:   n_state = S_SCAN;
                        REQ_CONTAINS: n_state = S_SCAN;
                    endcase
                end
            end
            S_POP_WAIT: n_state = S_DONE;
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_head       = r_head;
        n_occ        = r_occ;
        n_req        = r_req;
        n_key        = r_key;
        n_idx        = r_idx;
        n_kept       = r_kept;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_dvalid     = 1'b0;
        n_status     = r_status;
        n_popped     = r_popped;
        n_found      = r_found;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_popped = r_out_popped;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_wr_ptr;
        mem_wdata    = mem_rdata;
        mem_re       = 1'b0;
        mem_raddr    = r_rd_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req    = t_req'(i_req_type);
                    n_key    = DATA_W'(i_value);
                    n_status = ST_OK;
                    n_popped = '0;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_kept   = '0;
                    n_rd_ptr = r_head;
                    n_wr_ptr = r_head;
                    unique case (t_req'(i_req_type))
                        REQ_APPEND: begin
                            if (r_occ == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = tail;
                                mem_wdata = DATA_W'(i_value);
                                n_occ     = r_occ + 1'b1;
                            end
                        end
                        REQ_POP: begin
                            if (r_occ == '0) begin
                                n_status = ST_EMPTY;
                                n_popped = POP_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                            end
                        end
                        REQ_REMOVE, REQ_CONTAINS: begin
                        end
                    endcase
                end
            end
            S_POP_WAIT: begin
                n_popped = mem_rdata;
                n_head   = ptr_inc(r_head);
                n_occ    = r_occ - 1'b1;
            end
            S_SCAN: begin
                if (r_idx != r_occ) begin
                    mem_re   = 1'b1;
                    n_dvalid = 1'b1;
                    n_rd_ptr = ptr_inc(r_rd_ptr);
                    n_idx    = r_idx + 1'b1;
                end
                if (r_dvalid) begin
                    if (mem_rdata == r_key) begin
                        n_found = 1'b1;
                    end else if (r_req == REQ_REMOVE) begin
                        mem_we   = 1'b1;
                        n_wr_ptr = ptr_inc(r_wr_ptr);
                        n_kept   = r_kept + 1'b1;
                    end
                end
                if (scan_end && r_req == REQ_REMOVE) begin
                    n_occ = r_kept;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_popped = r_popped;
                    n_out_found  = r_found;
                    n_out_count  = COUNT_W'(r_occ);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_dvalid    <= n_dvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_kept       <= n_kept;
        r_rd_ptr     <= n_rd_ptr;
        r_wr_ptr     <= n_wr_ptr;
        r_status     <= n_status;
        r_popped     <= n_popped;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_popped <= n_out_popped;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_popped    = $signed(r_out_popped);
    assign o_found     = r_out_found;
    assign o_count     = r_out_count;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_scan_write_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && mem_we) |-> (r_req == REQ_REMOVE))
        else $error("RAM write during contains scan");

    a_kept_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_kept <= r_idx))
        else $error("compaction pointer ahead of scan");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req_type == REQ_APPEND && r_occ != CW'(DEPTH))
        |=> (r_occ == $past(r_occ) + 1'b1))
        else $error("append did not grow the list");

endmodule

`default_nettype wire

/* sv/olkr_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module olkr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sim/olkr_checker.sv */
// Checker for the ordered list: mirrors the list, predicts each result word and compares.
`default_nettype none

module olkr_list_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_stall,
    input  wire logic [1:0]                         i_req_type,
    input  wire logic signed [olkr_pkg::DATA_W-1:0] i_value,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic [1:0]                         i_status,
    input  wire logic signed [olkr_pkg::DATA_W-1:0] i_popped,
    input  wire logic                               i_found,
    input  wire logic [olkr_pkg::COUNT_W-1:0]       i_count,
    output int                                      o_errors,
    output int                                      o_pending,
    output int                                      o_results,
    output int                                      o_full_drops,
    output int                                      o_empty_pops,
    output int                                      o_key_hits
);

    timeunit 1ns;
    timeprecision 1ps;

    import olkr_pkg::*;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  popped;
        logic                      found;
        logic [COUNT_W-1:0]        count;
    } t_reply;

    logic signed [DATA_W-1:0] mirror_list[$];
    t_reply                   due_replies[$];

    int error_total   = 0;
    int pending_total = 0;
    int result_total  = 0;
    int full_total    = 0;
    int empty_total   = 0;
    int hit_total     = 0;

    assign o_errors     = error_total;
    assign o_pending    = pending_total;
    assign o_results    = result_total;
    assign o_full_drops = full_total;
    assign o_empty_pops = empty_total;
    assign o_key_hits   = hit_total;

    function automatic t_reply service_request(t_req req, logic signed [DATA_W-1:0] word);
        t_reply                   reply;
        logic signed [DATA_W-1:0] kept[$];
        reply = '0;
        reply.status = ST_OK;
        case (req)
            REQ_APPEND: begin
                if (mirror_list.size() >= DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    mirror_list.push_back(word);
                end
            end
            REQ_POP: begin
                if (mirror_list.size() == 0) begin
                    reply.status = ST_EMPTY;
                    reply.popped = POP_EMPTY;
                end else begin
                    reply.popped = mirror_list.pop_front();
                end
            end
            REQ_REMOVE: begin
                foreach (mirror_list[k]) begin
                    if (mirror_list[k] == word) begin
                        reply.found = 1'b1;
                    end else begin
                        kept.push_back(mirror_list[k]);
                    end
                end
                mirror_list = kept;
            end
            default: begin
                foreach (mirror_list[k]) begin
                    if (mirror_list[k] == word) begin
                        reply.found = 1'b1;
                    end
                end
            end
        endcase
        reply.count = COUNT_W'(mirror_list.size());
        return reply;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            mirror_list.delete();
            due_replies.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                want = service_request(t_req'(i_req_type), i_value);
                due_replies.push_back(want);
                if (want.status == ST_FULL) full_total++;
                if (want.status == ST_EMPTY) empty_total++;
                if (want.found) hit_total++;
            end
            if (i_out_valid && !i_out_stall) begin
                result_total++;
                if (due_replies.size() == 0) begin
                    $error("result word with no request waiting: status %0d, count %0d",
                           i_status, i_count);
                    error_total++;
                end else begin
                    want = due_replies.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        error_total++;
                    end
                    if (i_popped !== want.popped) begin
                        $error("popped: expected %0d, got %0d", want.popped, i_popped);
                        error_total++;
                    end
                    if (i_found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, i_found);
                        error_total++;
                    end
                    if (i_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, i_count);
                        error_total++;
                    end
                end
            end
        end
        pending_total = due_replies.size();
    end

endmodule

`default_nettype wire

/* sim/tb_ordered_list_with_key_removal_top.sv */
// Testbench top: drives requests into the ordered list and gives the verdict.
`default_nettype none

module tb_ordered_list_with_key_removal_top;

    timeunit 1ns;
    timeprecision 1ps;

    import olkr_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int          PHASE_WORDS  = 625;
    localparam int          BLOCK_WORDS  = 40;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 3 * (DEPTH + 3);

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [1:0]               req_type  = '0;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped;
    logic                     found;
    logic [COUNT_W-1:0]       count;

    int send_idle_pct = 14;
    int recv_idle_pct = 82;
    bit hold_req      = 1'b0;
    bit hold_seen     = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    int errors;
    int pending;
    int results;
    int full_drops;
    int empty_pops;
    int key_hits;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ordered_list_with_key_removal_top #(
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_value     (value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_popped    (popped),
        .o_found     (found),
        .o_count     (count)
    );

    olkr_list_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_value      (value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_popped     (popped),
        .i_found      (found),
        .i_count      (count),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_full_drops (full_drops),
        .o_empty_pops (empty_pops),
        .o_key_hits   (key_hits)
    );

    // hold off the result side once for a long stretch, else stall at random
    always @(posedge clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_ordered_list_with_key_removal_top: errors");
            $finish;
        end
    end

    task automatic send_word(t_req req, logic signed [DATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        value    <= word;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_operand();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return $urandom_range(5);
        if (roll < 70) begin
            case ($urandom_range(2))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                default: return -32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    // mode 0 fills the list, mode 1 drains it, anything else mixes
    function automatic t_req pick_request(int mode);
        int roll;
        int app;
        int pop;
        int rem;
        roll = $urandom_range(99);
        case (mode)
            0:       begin app = 70; pop = 10; rem = 10; end
            1:       begin app = 20; pop = 50; rem = 15; end
            default: begin app = 40; pop = 25; rem = 15; end
        endcase
        if (roll < app) return REQ_APPEND;
        if (roll < app + pop) return REQ_POP;
        if (roll < app + pop + rem) return REQ_REMOVE;
        return REQ_CONTAINS;
    endfunction

    initial begin : stimulus
        logic signed [DATA_W-1:0] fill_words [DEPTH];
        int                       mode;
        fill_words = '{32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0,
                       32'sh7fff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd1,
                       32'sh7fff_ffff, 32'sd2, 32'sd3, 32'sd4,
                       -32'sd1, 32'sd5, 32'sd6, 32'sd7};
        mode = 2;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(REQ_POP, 32'sd0);
        send_word(REQ_REMOVE, 32'sd0);
        send_word(REQ_CONTAINS, 32'sd0);
        foreach (fill_words[k]) send_word(REQ_APPEND, fill_words[k]);
        send_word(REQ_APPEND, 32'sd9);
        send_word(REQ_CONTAINS, 32'sh7fff_ffff);
        send_word(REQ_CONTAINS, 32'sd8);
        send_word(REQ_REMOVE, 32'sh7fff_ffff);
        send_word(REQ_POP, 32'sd0);
        send_word(REQ_REMOVE, 32'sd100);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct <= 82;
                    hold_req      <= 1'b1;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct <= 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % BLOCK_WORDS == 0) mode = $urandom_range(2);
                send_word(pick_request(mode), pick_operand());
            end
        end

        in_valid      <= 1'b0;
        recv_idle_pct <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d result words under sender, receiver and long hold-off stalls.",
                 results);
        $display("Dropped appends to a full list %0d, pops from an empty list %0d, key hits %0d.",
                 full_drops, empty_pops, key_hits);
        if (errors == 0) begin
            $display("tb_ordered_list_with_key_removal_top: clean");
        end else begin
            $display("tb_ordered_list_with_key_removal_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
